// File: hdl/pnf_pkg.sv
package pnf_pkg;

    // Fixed field widths of the stream words
    localparam int COORD_W    = 32;
    localparam int IDX_W      = 10;
    localparam int SEL_W      = 2;
    localparam int HASH_W     = 10;
    localparam int OCT_CFG_W  = 4;
    localparam int PERS_W     = 17;
    localparam int PERS_FRAC  = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int S_TDATA_W  = 80;

    // Parameter defaults
    localparam int DEF_TABLE_DEPTH   = 1024;
    localparam int DEF_MAX_OCTAVES   = 8;
    localparam int DEF_FRACTION_BITS = 16;

    // Corner hash constants
    localparam logic [33:0] HASH_ADD_FULL = 34'd4807526976;
    localparam logic [31:0] HASH_MUL_X    = 32'd1836311903;
    localparam logic [31:0] HASH_MUL_Y    = 32'd2971215073;
    localparam logic [31:0] HASH_ADD      = HASH_ADD_FULL[31:0];

    // Reduction of a hash into the table depth: multiply by 2^MOD_SHIFT / depth
    localparam int MOD_SHIFT = 20;

    // Quintic fade coefficients 6t^5 - 15t^4 + 10t^3
    localparam int FADE_C5 = 6;
    localparam int FADE_C4 = 15;
    localparam int FADE_C3 = 10;

    // Configuration registers
    localparam logic [CFG_ADDR_W-1:0] CFG_OCTAVES = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PERSIST = 1'b1;
    localparam logic [OCT_CFG_W-1:0]  OCT_RESET   = 4'd1;
    localparam logic [PERS_W-1:0]     PERS_RESET  = 17'd32768;
    localparam logic [PERS_W-1:0]     PERS_ONE    = 17'd65536;

    // Gradient selectors
    localparam logic [SEL_W-1:0] GRAD_POS_X = 2'd0;
    localparam logic [SEL_W-1:0] GRAD_NEG_X = 2'd1;
    localparam logic [SEL_W-1:0] GRAD_POS_Y = 2'd2;
    localparam logic [SEL_W-1:0] GRAD_NEG_Y = 2'd3;

    // Control that travels with every slot of the pipeline
    typedef struct packed {
        logic valid;
        logic load;
        logic first;
        logic last;
    } pnf_ctl_t;

endpackage

// File: hdl/pnf_ram.sv
module pnf_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/pnf_seq.sv
module pnf_seq #(
    parameter int MAX_OCTAVES   = pnf_pkg::DEF_MAX_OCTAVES,
    parameter int FRACTION_BITS = pnf_pkg::DEF_FRACTION_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            clr_done,
    input  logic                            in_valid,
    input  logic                            in_mode,
    input  logic [pnf_pkg::COORD_W-1:0]     in_x,
    input  logic [pnf_pkg::COORD_W-1:0]     in_y,
    input  logic [pnf_pkg::IDX_W-1:0]       in_idx,
    input  logic [pnf_pkg::SEL_W-1:0]       in_sel,
    input  logic [pnf_pkg::OCT_CFG_W-1:0]   octave_cfg,
    input  logic [pnf_pkg::PERS_W-1:0]      persist_cfg,
    output logic                            in_ready,
    output pnf_pkg::pnf_ctl_t               out_ctl,
    output logic [pnf_pkg::COORD_W-1:0]     out_x,
    output logic [pnf_pkg::COORD_W-1:0]     out_y,
    output logic [FRACTION_BITS:0]          out_amp,
    output logic [pnf_pkg::IDX_W-1:0]       out_idx,
    output logic [pnf_pkg::SEL_W-1:0]       out_sel
);

    import pnf_pkg::*;

    localparam int F   = FRACTION_BITS;
    localparam int OW  = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
    localparam int PEW = PERS_W + F;
    localparam int APW = 2 * F + 2;
    localparam logic [F:0] AMP_ONE = (F+1)'(1) << F;

    logic                busy_reg;
    logic                load_reg;
    logic [OW-1:0]       oct_reg;
    logic [OW-1:0]       nm1_reg;
    logic [COORD_W-1:0]  x_reg;
    logic [COORD_W-1:0]  y_reg;
    logic [F:0]          amp_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [SEL_W-1:0]    sel_reg;

    logic                last_now;
    logic                accept;
    logic [4:0]          raw5;
    logic [OW-1:0]       nm1_next;
    logic [PERS_W-1:0]   pers_sat;
    logic [PEW-1:0]      pers_wide;
    logic [F:0]          pers_f;
    logic [APW-1:0]      amp_prod;
    logic [F:0]          amp_next;

    // Issue slot ends on a load or on the final octave of a point
    assign last_now = busy_reg && (load_reg || (oct_reg == nm1_reg));
    assign in_ready = adv && clr_done && (!busy_reg || last_now);
    assign accept   = in_valid && in_ready;

    // Clamp the octave count into 1..MAX_OCTAVES
    always_comb
    begin
        raw5 = 5'(octave_cfg);
        if (raw5 == 5'd0)
        begin
            nm1_next = '0;
        end
        else if (raw5 > 5'(MAX_OCTAVES))
        begin
            nm1_next = OW'(MAX_OCTAVES - 1);
        end
        else
        begin
            nm1_next = OW'(raw5 - 5'd1);
        end
    end

    // Amplitude for the next octave: amp * persistence, truncated
    always_comb
    begin
        pers_sat  = (persist_cfg > PERS_ONE) ? PERS_ONE : persist_cfg;
        pers_wide = (PEW'(pers_sat) << F) >> PERS_FRAC;
        pers_f    = pers_wide[F:0];
        amp_prod  = APW'(amp_reg) * APW'(pers_f);
        amp_next  = amp_prod[2*F:F];
    end

    // Hold the point and step through its octaves, one per cycle while adv is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            load_reg <= 1'b0;
            oct_reg  <= '0;
            nm1_reg  <= '0;
        end
        else if (adv)
        begin
            if (busy_reg && !last_now)
            begin
                oct_reg <= oct_reg + OW'(1);
            end
            else if (accept)
            begin
                busy_reg <= 1'b1;
                load_reg <= in_mode;
                oct_reg  <= '0;
                nm1_reg  <= nm1_next;
            end
            else
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Coordinates double and amplitude decays between octaves
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (busy_reg && !last_now)
            begin
                x_reg   <= x_reg << 1;
                y_reg   <= y_reg << 1;
                amp_reg <= amp_next;
            end
            else if (accept)
            begin
                x_reg   <= in_x;
                y_reg   <= in_y;
                amp_reg <= AMP_ONE;
                idx_reg <= in_idx;
                sel_reg <= in_sel;
            end
        end
    end

    assign out_ctl.valid = busy_reg;
    assign out_ctl.load  = load_reg;
    assign out_ctl.first = (oct_reg == '0);
    assign out_ctl.last  = last_now;
    assign out_x         = x_reg;
    assign out_y         = y_reg;
    assign out_amp       = amp_reg;
    assign out_idx       = idx_reg;
    assign out_sel       = sel_reg;

endmodule

// File: hdl/pnf_core.sv
module pnf_core #(
    parameter int TABLE_DEPTH   = pnf_pkg::DEF_TABLE_DEPTH,
    parameter int FRACTION_BITS = pnf_pkg::DEF_FRACTION_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  pnf_pkg::pnf_ctl_t                  in_ctl,
    input  logic [pnf_pkg::COORD_W-1:0]        in_x,
    input  logic [pnf_pkg::COORD_W-1:0]        in_y,
    input  logic [FRACTION_BITS:0]             in_amp,
    input  logic [pnf_pkg::IDX_W-1:0]          in_idx,
    input  logic [pnf_pkg::SEL_W-1:0]          in_sel,
    output logic                               clr_done,
    output pnf_pkg::pnf_ctl_t                  out_ctl,
    output logic signed [2*FRACTION_BITS+3:0]  out_prod,
    output logic [FRACTION_BITS:0]             out_amp
);

    import pnf_pkg::*;

    localparam int F     = FRACTION_BITS;
    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int TTW   = 2 * F;
    localparam int PFW   = 2 * F + 4;
    localparam int DW    = F + 2;
    localparam int LPW   = 2 * F + 5;
    localparam int PW    = 2 * F + 4;
    localparam int MODW  = HASH_W + MOD_SHIFT;
    localparam int MOD_M = (1 << MOD_SHIFT) / TABLE_DEPTH;
    localparam logic signed [DW-1:0] ONE_S = DW'(1 << F);
    localparam logic [HASH_W-1:0] MUL_X_LO = HASH_MUL_X[HASH_W-1:0];
    localparam logic [HASH_W-1:0] MUL_Y_LO = HASH_MUL_Y[HASH_W-1:0];
    localparam logic [HASH_W-1:0] ADD_LO   = HASH_ADD[HASH_W-1:0];

    // Hash reduced into the table depth (reciprocal estimate, one correction)
    function automatic logic [AW-1:0] hmod(input logic [HASH_W-1:0] h);
        logic [MODW-1:0]   est;
        logic [MODW-1:0]   q;
        logic [MODW-1:0]   qd;
        logic [HASH_W-1:0] r;
        est = MODW'(h) * MODW'(MOD_M);
        q   = est >> MOD_SHIFT;
        qd  = q * MODW'(TABLE_DEPTH);
        r   = h - HASH_W'(qd);
        if (32'(r) >= TABLE_DEPTH)
        begin
            r = r - HASH_W'(TABLE_DEPTH);
        end
        return AW'(r);
    endfunction

    function automatic logic [F-1:0] cube_of(input logic [TTW-1:0] tt, input logic [F-1:0] t);
        logic [TTW-1:0] full;
        full = TTW'(tt[TTW-1:F]) * TTW'(t);
        return full[TTW-1:F];
    endfunction

    function automatic logic [F+3:0] poly_of(input logic [TTW-1:0] tt, input logic [F-1:0] t);
        logic [PFW-1:0] full;
        full = (PFW'(FADE_C3) << (2 * F)) + PFW'(FADE_C5) * PFW'(tt)
             - ((PFW'(FADE_C4) * PFW'(t)) << F);
        return full[PFW-1:F];
    endfunction

    function automatic logic [F:0] fade_of(input logic [F-1:0] t3, input logic [F+3:0] p);
        logic [PFW-1:0] full;
        full = PFW'(t3) * PFW'(p);
        return full[2*F:F];
    endfunction

    function automatic logic signed [DW-1:0] dot_of(input logic [SEL_W-1:0] g,
                                                   input logic signed [DW-1:0] dx,
                                                   input logic signed [DW-1:0] dy);
        logic signed [DW-1:0] r;
        case (g)
            GRAD_POS_X: r = dx;
            GRAD_NEG_X: r = -dx;
            GRAD_POS_Y: r = dy;
            default:    r = -dy;
        endcase
        return r;
    endfunction

    function automatic logic signed [DW-1:0] lerp_of(input logic signed [DW-1:0] a,
                                                    input logic signed [DW-1:0] b,
                                                    input logic [F:0] t);
        logic signed [DW:0]    diff;
        logic signed [LPW-1:0] prod;
        logic signed [LPW-1:0] sum;
        diff = (DW+1)'(b) - (DW+1)'(a);
        prod = LPW'(diff) * LPW'($signed({1'b0, t}));
        sum  = LPW'(a) + (prod >>> F);
        return DW'(sum);
    endfunction

    // ---------------- stage 1: cell and fraction ----------------
    pnf_ctl_t            ctl1_reg;
    logic [HASH_W-1:0]   cx1_reg, cy1_reg;
    logic [F-1:0]        fx1_reg, fy1_reg;
    logic [F:0]          amp1_reg;
    logic [IDX_W-1:0]    idx1_reg;
    logic [SEL_W-1:0]    sel1_reg;
    logic [COORD_W-1:0]  cx_full, cy_full;

    assign cx_full = COORD_W'($signed(in_x) >>> F);
    assign cy_full = COORD_W'($signed(in_y) >>> F);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx1_reg  <= cx_full[HASH_W-1:0];
            cy1_reg  <= cy_full[HASH_W-1:0];
            fx1_reg  <= in_x[F-1:0];
            fy1_reg  <= in_y[F-1:0];
            amp1_reg <= in_amp;
            idx1_reg <= in_idx;
            sel1_reg <= in_sel;
        end
    end

    // ---------------- stage 2: hash products and t squared ----------------
    pnf_ctl_t            ctl2_reg;
    logic [HASH_W-1:0]   mx2_reg, my2_reg;
    logic [TTW-1:0]      ttx2_reg, tty2_reg;
    logic [F-1:0]        fx2_reg, fy2_reg;
    logic [F:0]          amp2_reg;
    logic [IDX_W-1:0]    idx2_reg;
    logic [SEL_W-1:0]    sel2_reg;
    logic [2*HASH_W-1:0] mx_full, my_full;

    assign mx_full = (2*HASH_W)'(cx1_reg) * (2*HASH_W)'(MUL_X_LO);
    assign my_full = (2*HASH_W)'(cy1_reg) * (2*HASH_W)'(MUL_Y_LO) + (2*HASH_W)'(ADD_LO);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mx2_reg  <= mx_full[HASH_W-1:0];
            my2_reg  <= my_full[HASH_W-1:0];
            ttx2_reg <= TTW'(fx1_reg) * TTW'(fx1_reg);
            tty2_reg <= TTW'(fy1_reg) * TTW'(fy1_reg);
            fx2_reg  <= fx1_reg;
            fy2_reg  <= fy1_reg;
            amp2_reg <= amp1_reg;
            idx2_reg <= idx1_reg;
            sel2_reg <= sel1_reg;
        end
    end

    // ---------------- stage 3: corner hashes, fade parts ----------------
    pnf_ctl_t            ctl3_reg;
    logic [HASH_W-1:0]   h3_reg [4];
    logic [F-1:0]        t3x3_reg, t3y3_reg;
    logic [F+3:0]        px3_reg, py3_reg;
    logic [F-1:0]        fx3_reg, fy3_reg;
    logic [F:0]          amp3_reg;
    logic [IDX_W-1:0]    idx3_reg;
    logic [SEL_W-1:0]    sel3_reg;
    logic [HASH_W-1:0]   mxa, mya;

    assign mxa = mx2_reg + MUL_X_LO;
    assign mya = my2_reg + MUL_Y_LO;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h3_reg[0] <= mx2_reg ^ my2_reg;
            h3_reg[1] <= mxa ^ my2_reg;
            h3_reg[2] <= mx2_reg ^ mya;
            h3_reg[3] <= mxa ^ mya;
            t3x3_reg  <= cube_of(ttx2_reg, fx2_reg);
            t3y3_reg  <= cube_of(tty2_reg, fy2_reg);
            px3_reg   <= poly_of(ttx2_reg, fx2_reg);
            py3_reg   <= poly_of(tty2_reg, fy2_reg);
            fx3_reg   <= fx2_reg;
            fy3_reg   <= fy2_reg;
            amp3_reg  <= amp2_reg;
            idx3_reg  <= idx2_reg;
            sel3_reg  <= sel2_reg;
        end
    end

    // ---------------- stage 4: table lookup and fade ----------------
    pnf_ctl_t            ctl4_reg;
    logic [F:0]          u4_reg, v4_reg;
    logic [F-1:0]        fx4_reg, fy4_reg;
    logic [F:0]          amp4_reg;
    logic [SEL_W-1:0]    grad4 [4];
    logic                clr_busy_reg;
    logic [AW-1:0]       clr_cnt_reg;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [SEL_W-1:0]    ram_wdata;
    logic                idx_ok;

    assign idx_ok    = (32'(idx3_reg) < TABLE_DEPTH);
    assign ram_we    = clr_busy_reg || (adv && ctl3_reg.valid && ctl3_reg.load && idx_ok);
    assign ram_waddr = clr_busy_reg ? clr_cnt_reg : AW'(idx3_reg);
    assign ram_wdata = clr_busy_reg ? '0 : sel3_reg;
    assign clr_done  = !clr_busy_reg;

    // Sweep zeros through the table after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(TABLE_DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // One table copy per corner, all written alike
    for (genvar c = 0; c < 4; c++)
    begin : g_corner
        pnf_ram #(
            .WIDTH (SEL_W),
            .DEPTH (TABLE_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we),
            .waddr (ram_waddr),
            .wdata (ram_wdata),
            .re    (adv),
            .raddr (hmod(h3_reg[c])),
            .rdata (grad4[c])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u4_reg   <= fade_of(t3x3_reg, px3_reg);
            v4_reg   <= fade_of(t3y3_reg, py3_reg);
            fx4_reg  <= fx3_reg;
            fy4_reg  <= fy3_reg;
            amp4_reg <= amp3_reg;
        end
    end

    // ---------------- stage 5: corner dot products ----------------
    pnf_ctl_t              ctl5_reg;
    logic signed [DW-1:0]  d5_reg [4];
    logic [F:0]            u5_reg, v5_reg;
    logic [F:0]            amp5_reg;
    logic signed [DW-1:0]  dx0, dx1, dy0, dy1;

    assign dx0 = $signed(DW'(fx4_reg));
    assign dy0 = $signed(DW'(fy4_reg));
    assign dx1 = dx0 - ONE_S;
    assign dy1 = dy0 - ONE_S;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d5_reg[0] <= dot_of(grad4[0], dx0, dy0);
            d5_reg[1] <= dot_of(grad4[1], dx1, dy0);
            d5_reg[2] <= dot_of(grad4[2], dx0, dy1);
            d5_reg[3] <= dot_of(grad4[3], dx1, dy1);
            u5_reg    <= u4_reg;
            v5_reg    <= v4_reg;
            amp5_reg  <= amp4_reg;
        end
    end

    // ---------------- stage 6: interpolate along x ----------------
    pnf_ctl_t              ctl6_reg;
    logic signed [DW-1:0]  top6_reg, bot6_reg;
    logic [F:0]            v6_reg;
    logic [F:0]            amp6_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            top6_reg <= lerp_of(d5_reg[0], d5_reg[1], u5_reg);
            bot6_reg <= lerp_of(d5_reg[2], d5_reg[3], u5_reg);
            v6_reg   <= v5_reg;
            amp6_reg <= amp5_reg;
        end
    end

    // ---------------- stage 7: interpolate along y ----------------
    pnf_ctl_t              ctl7_reg;
    logic signed [DW-1:0]  n7_reg;
    logic [F:0]            amp7_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n7_reg   <= lerp_of(top6_reg, bot6_reg, v6_reg);
            amp7_reg <= amp6_reg;
        end
    end

    // ---------------- stage 8: weight by amplitude ----------------
    pnf_ctl_t              ctl8_reg;
    logic signed [PW-1:0]  prod8_reg;
    logic [F:0]            amp8_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod8_reg <= PW'(n7_reg) * PW'($signed({1'b0, amp7_reg}));
            amp8_reg  <= amp7_reg;
        end
    end

    // Advance control bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
            ctl6_reg <= '0;
            ctl7_reg <= '0;
            ctl8_reg <= '0;
        end
        else if (adv)
        begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
            ctl6_reg <= ctl5_reg;
            ctl7_reg <= ctl6_reg;
            ctl8_reg <= ctl7_reg;
        end
    end

    assign out_ctl  = ctl8_reg;
    assign out_prod = prod8_reg;
    assign out_amp  = amp8_reg;

endmodule

// File: hdl/pnf_accdiv.sv
module pnf_accdiv #(
    parameter int MAX_OCTAVES   = pnf_pkg::DEF_MAX_OCTAVES,
    parameter int FRACTION_BITS = pnf_pkg::DEF_FRACTION_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  pnf_pkg::pnf_ctl_t                  in_ctl,
    input  logic signed [2*FRACTION_BITS+3:0]  in_prod,
    input  logic [FRACTION_BITS:0]             in_amp,
    output logic                               out_valid,
    output logic [FRACTION_BITS+1:0]           out_value
);

    import pnf_pkg::*;

    localparam int F  = FRACTION_BITS;
    localparam int CW = $clog2(MAX_OCTAVES + 1);
    localparam int MW = 2 * F + CW;
    localparam int SW = MW + 1;
    localparam int TW = F + CW;
    localparam int QW = F + 1;
    localparam int NW = F + 2;

    logic signed [SW-1:0] sum_reg;
    logic [TW-1:0]        tot_reg;
    logic signed [SW-1:0] sum_next;
    logic [TW-1:0]        tot_next;
    logic                 take;

    logic                 dv_vld_reg [QW+1];
    logic                 neg_reg    [QW+1];
    logic [MW-1:0]        rem_reg    [QW+1];
    logic [QW-1:0]        quo_reg    [QW+1];
    logic [TW-1:0]        den_reg    [QW+1];
    logic [MW-1:0]        rem_nx     [QW];
    logic [QW-1:0]        quo_nx     [QW];
    logic [MW-1:0]        trial      [QW];

    logic                 out_vld_reg;
    logic [NW-1:0]        out_val_reg;
    logic [NW-1:0]        quo_ext;

    // Running weighted sum and amplitude total of one point
    assign take     = in_ctl.valid && !in_ctl.load;
    assign sum_next = in_ctl.first ? SW'(in_prod) : sum_reg + SW'(in_prod);
    assign tot_next = in_ctl.first ? TW'(in_amp) : tot_reg + TW'(in_amp);

    always_ff @(posedge clk)
    begin
        if (adv && take)
        begin
            sum_reg <= sum_next;
            tot_reg <= tot_next;
        end
    end

    // One quotient bit per stage, restoring on magnitudes
    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            trial[k]  = MW'(den_reg[k]) << (QW - 1 - k);
            rem_nx[k] = rem_reg[k];
            quo_nx[k] = quo_reg[k];
            if (rem_reg[k] >= trial[k])
            begin
                rem_nx[k]             = rem_reg[k] - trial[k];
                quo_nx[k][QW - 1 - k] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg_reg[0] <= sum_next[SW-1];
            rem_reg[0] <= sum_next[SW-1] ? MW'(-sum_next) : MW'(sum_next);
            quo_reg[0] <= '0;
            den_reg[0] <= tot_next;
            for (int k = 0; k < QW; k++)
            begin
                neg_reg[k+1] <= neg_reg[k];
                rem_reg[k+1] <= rem_nx[k];
                quo_reg[k+1] <= quo_nx[k];
                den_reg[k+1] <= den_reg[k];
            end
        end
    end

    // Restore the sign: truncation toward zero
    assign quo_ext = NW'(quo_reg[QW]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_val_reg <= neg_reg[QW] ? -quo_ext : quo_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
            begin
                dv_vld_reg[k] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            dv_vld_reg[0] <= take && in_ctl.last;
            for (int k = 0; k < QW; k++)
            begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
            out_vld_reg <= dv_vld_reg[QW];
        end
    end

    assign out_valid = out_vld_reg;
    assign out_value = out_val_reg;

endmodule

// File: hdl/perlin_noise_2d_fractal_top.sv
// Fractal 2D gradient noise. Each input word either loads one gradient table
// entry (tuser = 1, no result word) or evaluates the noise at a Q16.16 point
// (tuser = 0, one result word). A point holds the issue slot for octave_count
// octaves (1 to MAX_OCTAVES), one octave per cycle into the shared octave
// pipeline while the result word is not held; a load holds it for one slot,
// and the next word can be taken as the last slot of a point issues. The
// issue slot is the only loop: the octave pipeline (8 stages, four table
// copies read together) and the divider (FRACTION_BITS+1 stages, one quotient
// bit each) take a new slot every cycle while the result word is not held.
// After reset s_tready stays low while the gradient table is zeroed;
// configuration writes are taken at any time but should only be made while
// the block is idle.
module perlin_noise_2d_fractal_top #(
    parameter int TABLE_DEPTH   = pnf_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_OCTAVES   = pnf_pkg::DEF_MAX_OCTAVES,
    parameter int FRACTION_BITS = pnf_pkg::DEF_FRACTION_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // coord_x[31:0], coord_y[63:32], table_index[73:64], table_entry[75:74]
    input  logic [pnf_pkg::S_TDATA_W-1:0]      s_tdata,
    // mode[0]
    input  logic                               s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // noise_value[FRACTION_BITS+1:0], zero fill above
    output logic [((FRACTION_BITS+9)/8)*8-1:0] m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_we,
    input  logic [pnf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pnf_pkg::PERS_W-1:0]         cfg_wdata
);

    import pnf_pkg::*;

    localparam int F     = FRACTION_BITS;
    localparam int OUT_W = ((F + 9) / 8) * 8;

    logic [OCT_CFG_W-1:0] oct_cfg_reg;
    logic [PERS_W-1:0]    pers_cfg_reg;
    logic                 adv;
    logic                 clr_done;

    pnf_ctl_t             seq_ctl;
    logic [COORD_W-1:0]   seq_x, seq_y;
    logic [F:0]           seq_amp;
    logic [IDX_W-1:0]     seq_idx;
    logic [SEL_W-1:0]     seq_sel;

    pnf_ctl_t             core_ctl;
    logic signed [2*F+3:0] core_prod;
    logic [F:0]           core_amp;
    logic [F+1:0]         noise;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_cfg_reg  <= OCT_RESET;
            pers_cfg_reg <= PERS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_OCTAVES: oct_cfg_reg  <= cfg_wdata[OCT_CFG_W-1:0];
                CFG_PERSIST: pers_cfg_reg <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    // Whole pipeline moves unless the result word is held
    assign adv = !m_tvalid || m_tready;

    pnf_seq #(
        .MAX_OCTAVES   (MAX_OCTAVES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .clr_done    (clr_done),
        .in_valid    (s_tvalid),
        .in_mode     (s_tuser),
        .in_x        (s_tdata[31:0]),
        .in_y        (s_tdata[63:32]),
        .in_idx      (s_tdata[73:64]),
        .in_sel      (s_tdata[75:74]),
        .octave_cfg  (oct_cfg_reg),
        .persist_cfg (pers_cfg_reg),
        .in_ready    (s_tready),
        .out_ctl     (seq_ctl),
        .out_x       (seq_x),
        .out_y       (seq_y),
        .out_amp     (seq_amp),
        .out_idx     (seq_idx),
        .out_sel     (seq_sel)
    );

    pnf_core #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_ctl   (seq_ctl),
        .in_x     (seq_x),
        .in_y     (seq_y),
        .in_amp   (seq_amp),
        .in_idx   (seq_idx),
        .in_sel   (seq_sel),
        .clr_done (clr_done),
        .out_ctl  (core_ctl),
        .out_prod (core_prod),
        .out_amp  (core_amp)
    );

    pnf_accdiv #(
        .MAX_OCTAVES   (MAX_OCTAVES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_accdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_ctl    (core_ctl),
        .in_prod   (core_prod),
        .in_amp    (core_amp),
        .out_valid (m_tvalid),
        .out_value (noise)
    );

    assign m_tdata = OUT_W'(noise);

endmodule

// File: hdl/pnf_checker.sv
module pnf_checker #(
    parameter int FRACTION_BITS = pnf_pkg::DEF_FRACTION_BITS
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [((FRACTION_BITS+9)/8)*8-1:0] m_tdata
);

    localparam int NW    = FRACTION_BITS + 2;
    localparam int OUT_W = ((FRACTION_BITS + 9) / 8) * 8;
    localparam logic signed [NW-1:0] ONE_S = NW'(1 << FRACTION_BITS);

    // Held result word stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Normalized noise stays within -1..1
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[NW-1:0]) <= ONE_S)
                  && ($signed(m_tdata[NW-1:0]) >= -ONE_S))
        else $error("noise value out of range");

    // Fill bits above the noise value are zero
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata >> NW) == OUT_W'(0)))
        else $error("fill bits set");

    // Table clearing blocks input right after reset
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !s_tready)
        else $error("input taken before table clear");

endmodule

bind perlin_noise_2d_fractal_top pnf_checker #(
    .FRACTION_BITS (FRACTION_BITS)
) u_pnf_checker (.*);
